// ===== rtl/core/nrt_pkg.sv =====
// shared types and constants for the neighbor route table
package nrt_pkg;

  localparam int unsigned CountOutW = 5;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 80;

  typedef enum logic [2:0] {
    CMD_UPDATE   = 3'd0,
    CMD_NEXT_HOP = 3'd1,
    CMD_FIND     = 3'd2,
    CMD_PRUNE    = 3'd3,
    CMD_TICK     = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [15:0]       addr;
    logic signed [7:0] rssi;
    logic [7:0]        hops;
    logic              ble;
    logic              lora;
  } item_t;

  typedef struct packed {
    logic [15:0]       addr;
    logic signed [7:0] rssi;
    logic [7:0]        hops;
    logic [31:0]       seen;
    logic              lora;
    logic              ble;
  } entry_t;

  typedef struct packed {
    logic [15:0]          route_addr;
    logic                 found;
    logic signed [7:0]    entry_rssi;
    logic [7:0]           entry_hops;
    logic [31:0]          entry_seen;
    logic                 entry_ble;
    logic                 entry_lora;
    logic                 dropped;
    logic [CountOutW-1:0] entry_count;
  } result_t;

endpackage

// ===== rtl/core/neighbor_route_table_top.sv =====
// neighbor route table: stream ports, max age register and result register
// update, next hop and find scan the entries with one memory read per entry, stopping early
// on an address match; prune visits each entry and moves the last entry into a stale slot;
// tick and unused commands go straight to the result; one item at a time
// reset clears count, clock, max age and handshakes; entry memory is not cleared,
// entries beyond the count are never read, so no clearing pass is needed
module neighbor_route_table_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // addr[15:0] rssi[23:16] hops[31:24] ble[32] lora[33]
  input  logic [nrt_pkg::InDataW-1:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,  // command[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // route_addr[15:0] found[16] entry_rssi[24:17] entry_hops[32:25] entry_seen[64:33]
  // entry_ble[65] entry_lora[66] dropped[67] entry_count[72:68]
  output logic [nrt_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);
  import nrt_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic        max_age_q;
  logic [31:0] max_age_val_q;
  logic        seq_ready;
  logic        seq_done;
  logic        res_ready;
  result_t     seq_res;
  result_t     out_q;
  logic        out_valid_q;
  item_t       item;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  entry_t      rd_data;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  entry_t      wr_data;

  assign item.addr = s_axis_tdata[15:0];
  assign item.rssi = s_axis_tdata[23:16];
  assign item.hops = s_axis_tdata[31:24];
  assign item.ble  = s_axis_tdata[32];
  assign item.lora = s_axis_tdata[33];

  assign s_axis_tready = seq_ready;
  assign res_ready     = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q     <= 1'b0;
      max_age_val_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_age_q     <= 1'b1;
        max_age_val_q <= cfg_wdata_i;
      end
      if (seq_done && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done && res_ready) begin
      out_q <= seq_res;
    end
  end

  nrt_seq #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_axis_tvalid && seq_ready),
    .ready_o    (seq_ready),
    .cmd_i      (s_axis_tuser),
    .item_i     (item),
    .max_age_i  (max_age_q ? max_age_val_q : 32'd0),
    .done_o     (seq_done),
    .res_ready_i(res_ready),
    .res_o      (seq_res),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  nrt_entry_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.entry_count, out_q.dropped, out_q.entry_lora,
                          out_q.entry_ble, out_q.entry_seen, out_q.entry_hops,
                          out_q.entry_rssi, out_q.found, out_q.route_addr};

endmodule

// ===== rtl/core/nrt_entry_ram.sv =====
// single-port-read, single-port-write entry memory with registered read data
module nrt_entry_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output nrt_pkg::entry_t rd_data_o,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  nrt_pkg::entry_t wr_data_i
);
  import nrt_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/nrt_seq.sv =====
// command sequencer: scans, updates and compacts the entry memory
module nrt_seq #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             ready_o,
  input  logic [2:0]       cmd_i,
  input  nrt_pkg::item_t   item_i,
  input  logic [31:0]      max_age_i,
  output logic             done_o,
  input  logic             res_ready_i,
  output nrt_pkg::result_t res_o,
  output logic             rd_en_o,
  output logic [AW-1:0]    rd_addr_o,
  input  nrt_pkg::entry_t  rd_data_i,
  output logic             wr_en_o,
  output logic [AW-1:0]    wr_addr_o,
  output nrt_pkg::entry_t  wr_data_o
);
  import nrt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PR_RD,
    S_PR_CHK,
    S_PR_MOVE,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  item_t             item_q, item_d;
  logic [CW-1:0]     count_q, count_d;
  logic [31:0]       clock_q, clock_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pend_idx_q, pend_idx_d;
  logic              hit_q, hit_d;
  logic [AW-1:0]     hit_idx_q, hit_idx_d;
  entry_t            hit_ent_q, hit_ent_d;
  logic              have_best_q, have_best_d;
  logic signed [7:0] best_rssi_q, best_rssi_d;
  logic [15:0]       best_addr_q, best_addr_d;
  result_t           res_q, res_d;
  logic [31:0]       age;
  logic              scan_end;

  assign age      = clock_q - rd_data_i.seen;
  assign scan_end = hit_q || (!pend_q && (idx_q >= count_q));

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    item_d      = item_q;
    count_d     = count_q;
    clock_d     = clock_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_ent_d   = hit_ent_q;
    have_best_d = have_best_q;
    best_rssi_d = best_rssi_q;
    best_addr_d = best_addr_q;
    res_d       = res_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = idx_q[AW-1:0];
    wr_en_o     = 1'b0;
    wr_addr_o   = idx_q[AW-1:0];
    wr_data_o   = rd_data_i;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d       = cmd_e'(cmd_i);
          item_d      = item_i;
          idx_d       = '0;
          hit_d       = 1'b0;
          have_best_d = 1'b0;
          res_d       = '0;
          case (cmd_e'(cmd_i))
            CMD_UPDATE, CMD_NEXT_HOP, CMD_FIND: begin
              state_d = S_SCAN;
            end
            CMD_PRUNE: begin
              state_d = S_PR_RD;
            end
            CMD_TICK: begin
              clock_d           = clock_q + 32'd1;
              res_d.entry_count = CountOutW'(count_q);
              state_d           = S_DONE;
            end
            default: begin
              res_d.entry_count = CountOutW'(count_q);
              state_d           = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // one read issued per cycle, compared in the cycle after
        if (!hit_q && (idx_q < count_q)) begin
          rd_en_o    = 1'b1;
          idx_d      = idx_q + 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = idx_q[AW-1:0];
        end
        if (pend_q && !hit_q) begin
          if (rd_data_i.addr == item_q.addr) begin
            hit_d     = 1'b1;
            hit_idx_d = pend_idx_q;
            hit_ent_d = rd_data_i;
          end
          // strict compare keeps the first of equal strengths
          if (!have_best_q || ($signed(rd_data_i.rssi) > $signed(best_rssi_q))) begin
            have_best_d = 1'b1;
            best_rssi_d = rd_data_i.rssi;
            best_addr_d = rd_data_i.addr;
          end
        end
        if (scan_end) begin
          pend_d           = 1'b0;
          wr_data_o.addr   = item_q.addr;
          wr_data_o.rssi   = item_q.rssi;
          wr_data_o.hops   = item_q.hops;
          wr_data_o.seen   = clock_q;
          wr_data_o.ble    = item_q.ble;
          wr_data_o.lora   = item_q.lora;
          case (cmd_q)
            CMD_UPDATE: begin
              if (hit_q) begin
                wr_en_o   = 1'b1;
                wr_addr_o = hit_idx_q;
              end else if (count_q < CW'(DEPTH)) begin
                wr_en_o   = 1'b1;
                wr_addr_o = count_q[AW-1:0];
                count_d   = count_q + 1'b1;
              end else begin
                res_d.dropped = 1'b1;
              end
            end
            CMD_NEXT_HOP: begin
              if (hit_q) begin
                res_d.route_addr = item_q.addr;
              end else if (have_best_q) begin
                res_d.route_addr = best_addr_q;
              end
            end
            CMD_FIND: begin
              if (hit_q) begin
                res_d.found      = 1'b1;
                res_d.entry_rssi = hit_ent_q.rssi;
                res_d.entry_hops = hit_ent_q.hops;
                res_d.entry_seen = hit_ent_q.seen;
                res_d.entry_ble  = hit_ent_q.ble;
                res_d.entry_lora = hit_ent_q.lora;
              end
            end
            default: begin
            end
          endcase
          res_d.entry_count = CountOutW'(count_d);
          state_d           = S_DONE;
        end
      end

      S_PR_RD: begin
        if (idx_q < count_q) begin
          rd_en_o = 1'b1;
          state_d = S_PR_CHK;
        end else begin
          res_d.entry_count = CountOutW'(count_q);
          state_d           = S_DONE;
        end
      end

      S_PR_CHK: begin
        if (age > max_age_i) begin
          // stale: fetch the last entry to fill the hole
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(count_q - 1'b1);
          state_d   = S_PR_MOVE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_PR_RD;
        end
      end

      S_PR_MOVE: begin
        // moved entry is rechecked at the same index
        wr_en_o = 1'b1;
        count_d = count_q - 1'b1;
        state_d = S_PR_RD;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      clock_q <= '0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      clock_q <= clock_d;
      pend_q  <= pend_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    item_q      <= item_d;
    idx_q       <= idx_d;
    pend_idx_q  <= pend_idx_d;
    hit_idx_q   <= hit_idx_d;
    hit_ent_q   <= hit_ent_d;
    have_best_q <= have_best_d;
    best_rssi_q <= best_rssi_d;
    best_addr_q <= best_addr_d;
    res_q       <= res_d;
  end

  assign ready_o = (state_q == S_IDLE);
  assign done_o  = (state_q == S_DONE);
  assign res_o   = res_q;

endmodule

// ===== dv/neighbor_route_table_top_tb.sv =====
// testbench for the neighbor route table: directed and random commands, checked against typed results or a predictor
`timescale 1ns / 1ps

module neighbor_route_table_top_tb;
  import nrt_pkg::*;

  localparam int Depth      = 16;
  localparam int QuietLimit = 3000;
  localparam int HoldCycles = 400;
  localparam int PoolSize   = 20;
  localparam int PhaseItems = 125;

  localparam logic [2:0] CmdUnusedFirst = 3'd5;
  localparam logic [2:0] CmdUnusedLast  = 3'd7;

  localparam result_t NoRes = '0;

  typedef struct {
    logic [2:0] cmd;
    item_t      it;
    bit         typed;
    result_t    res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;  // addr[15:0] rssi[23:16] hops[31:24] ble[32] lora[33]
  logic [2:0]  s_axis_tuser;  // command[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // route_addr[15:0] found[16] entry_rssi[24:17] entry_hops[32:25] entry_seen[64:33]
  // entry_ble[65] entry_lora[66] dropped[67] entry_count[72:68]
  logic [79:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  // predictor state
  entry_t      nbr_tbl[Depth];
  int          nbr_count = 0;
  logic [31:0] now_ms    = '0;
  logic [31:0] age_limit = '0;

  result_t     pending_results[$];
  int          mismatch_cnt  = 0;
  int          quiet_cycles  = 0;
  int          hold_left     = 0;
  bit          hold_req      = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          drv_typed     = 1'b0;
  result_t     drv_typed_res = '0;
  logic [15:0] addr_pool[PoolSize];

  always #5 clk_i = ~clk_i;

  neighbor_route_table_top #(
    .DEPTH(Depth)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // applies one command to the neighbor table copy and returns the result it gives
  function automatic result_t route_table_step(input logic [2:0] cmd, input item_t it);
    result_t     r;
    int          hit_idx;
    int          best;
    int          i;
    logic [31:0] age;
    r = '0;
    hit_idx = -1;
    for (i = 0; i < nbr_count; i++) begin
      if (hit_idx < 0 && nbr_tbl[i].addr == it.addr) hit_idx = i;
    end
    case (cmd)
      CMD_UPDATE: begin
        if (hit_idx < 0 && nbr_count < Depth) begin
          hit_idx = nbr_count;
          nbr_count++;
        end
        if (hit_idx < 0) r.dropped = 1'b1;
        else nbr_tbl[hit_idx] = '{it.addr, it.rssi, it.hops, now_ms, it.lora, it.ble};
      end
      CMD_NEXT_HOP: begin
        if (hit_idx >= 0) begin
          r.route_addr = it.addr;
        end else if (nbr_count > 0) begin
          // first entry with the strongest signal wins a tie
          best = 0;
          for (i = 1; i < nbr_count; i++) begin
            if ($signed(nbr_tbl[i].rssi) > $signed(nbr_tbl[best].rssi)) best = i;
          end
          r.route_addr = nbr_tbl[best].addr;
        end
      end
      CMD_FIND: begin
        if (hit_idx >= 0) begin
          r.found      = 1'b1;
          r.entry_rssi = nbr_tbl[hit_idx].rssi;
          r.entry_hops = nbr_tbl[hit_idx].hops;
          r.entry_seen = nbr_tbl[hit_idx].seen;
          r.entry_ble  = nbr_tbl[hit_idx].ble;
          r.entry_lora = nbr_tbl[hit_idx].lora;
        end
      end
      CMD_PRUNE: begin
        // a removed slot takes the last entry, which is checked again in place
        i = 0;
        while (i < nbr_count) begin
          age = now_ms - nbr_tbl[i].seen;
          if (age > age_limit) begin
            nbr_tbl[i] = nbr_tbl[nbr_count - 1];
            nbr_count--;
          end else begin
            i++;
          end
        end
      end
      CMD_TICK: begin
        now_ms = now_ms + 32'd1;
      end
      default: begin
      end
    endcase
    r.entry_count = 5'(nbr_count);
    return r;
  endfunction

  function automatic item_t mk(input logic [15:0] a, input logic [7:0] rs, input logic [7:0] h,
                               input logic b, input logic l);
    item_t x;
    x.addr = a;
    x.rssi = rs;
    x.hops = h;
    x.ble  = b;
    x.lora = l;
    return x;
  endfunction

  function automatic result_t res_of(input logic [15:0] route, input logic fnd,
                                     input logic [7:0] rs, input logic [7:0] h,
                                     input logic [31:0] seen, input logic b, input logic l,
                                     input logic drop, input logic [4:0] cnt);
    result_t r;
    r.route_addr  = route;
    r.found       = fnd;
    r.entry_rssi  = rs;
    r.entry_hops  = h;
    r.entry_seen  = seen;
    r.entry_ble   = b;
    r.entry_lora  = l;
    r.dropped     = drop;
    r.entry_count = cnt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  // both handshakes, prediction, checking and the watchdog
  always @(posedge clk_i) begin : mon
    item_t   in_it;
    result_t want;
    result_t got;
    if (rst_ni) begin
      quiet_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        in_it.addr = s_axis_tdata[15:0];
        in_it.rssi = s_axis_tdata[23:16];
        in_it.hops = s_axis_tdata[31:24];
        in_it.ble  = s_axis_tdata[32];
        in_it.lora = s_axis_tdata[33];
        want = route_table_step(s_axis_tuser, in_it);
        if (drv_typed) want = drv_typed_res;
        pending_results.push_back(want);
        quiet_cycles = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        got.route_addr  = m_axis_tdata[15:0];
        got.found       = m_axis_tdata[16];
        got.entry_rssi  = m_axis_tdata[24:17];
        got.entry_hops  = m_axis_tdata[32:25];
        got.entry_seen  = m_axis_tdata[64:33];
        got.entry_ble   = m_axis_tdata[65];
        got.entry_lora  = m_axis_tdata[66];
        got.dropped     = m_axis_tdata[67];
        got.entry_count = m_axis_tdata[72:68];
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("result %h with nothing pending", m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("route_addr", 32'(want.route_addr), 32'(got.route_addr));
          check_field("found", 32'(want.found), 32'(got.found));
          check_field("entry_rssi", 32'(want.entry_rssi), 32'(got.entry_rssi));
          check_field("entry_hops", 32'(want.entry_hops), 32'(got.entry_hops));
          check_field("entry_seen", want.entry_seen, got.entry_seen);
          check_field("entry_ble", 32'(want.entry_ble), 32'(got.entry_ble));
          check_field("entry_lora", 32'(want.entry_lora), 32'(got.entry_lora));
          check_field("dropped", 32'(want.dropped), 32'(got.dropped));
          check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        end
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout: no item moved for %0d cycles", QuietLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(input logic [2:0] cmd, input item_t it, input bit typed,
                           input result_t res);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 40'({$urandom, $urandom});
      s_axis_tuser  <= 3'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'd0, it.lora, it.ble, it.hops, it.rssi, it.addr};
    drv_typed     <= typed;
    drv_typed_res <= res;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_age(input logic [31:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    age_limit = v;
  endtask

  task automatic pick_random(output logic [2:0] cmd, output item_t it);
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) cmd = CMD_UPDATE;
    else if (roll < 55) cmd = CMD_NEXT_HOP;
    else if (roll < 72) cmd = CMD_FIND;
    else if (roll < 88) cmd = CMD_TICK;
    else if (roll < 94) cmd = CMD_PRUNE;
    else cmd = 3'($urandom_range(CmdUnusedLast, CmdUnusedFirst));
    // mostly a small address pool so the table fills, hits and drops
    if ($urandom_range(99) < 80) it.addr = addr_pool[$urandom_range(PoolSize - 1)];
    else it.addr = 16'($urandom);
    case ($urandom_range(5))
      0: it.rssi = 8'sh80;
      1: it.rssi = 8'sh7F;
      2: it.rssi = 8'sh00;
      default: it.rssi = 8'($urandom);
    endcase
    it.hops = 8'($urandom);
    it.ble  = 1'($urandom);
    it.lora = 1'($urandom);
  endtask

  initial begin : stim
    dir_row_t    dir_rows[$];
    logic [2:0]  cmd;
    item_t       it;
    logic [31:0] age_val;
    int          send_pct[3];
    int          recv_pct[3];
    send_pct = '{32, 72, 0};
    recv_pct = '{72, 32, 0};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table: next hop, find, prune, then an unused command with every field at its maximum
    dir_rows.push_back(dir_row_t'{CMD_NEXT_HOP, mk(16'h1234, 8'h00, 8'h00, 1'b0, 1'b0), 1'b1,
                                  res_of(16'h0, 0, 8'h00, 8'h00, 32'd0, 0, 0, 0, 5'd0)});
    dir_rows.push_back(dir_row_t'{CMD_FIND, mk(16'hFFFF, 8'h00, 8'h00, 1'b0, 1'b0), 1'b1,
                                  res_of(16'h0, 0, 8'h00, 8'h00, 32'd0, 0, 0, 0, 5'd0)});
    dir_rows.push_back(dir_row_t'{CMD_PRUNE, mk(16'h0000, 8'h80, 8'hFF, 1'b1, 1'b0), 1'b1,
                                  res_of(16'h0, 0, 8'h00, 8'h00, 32'd0, 0, 0, 0, 5'd0)});
    dir_rows.push_back(dir_row_t'{CmdUnusedFirst, mk(16'hFFFF, 8'h7F, 8'hFF, 1'b1, 1'b1), 1'b1,
                                  res_of(16'h0, 0, 8'h00, 8'h00, 32'd0, 0, 0, 0, 5'd0)});
    // field extremes stored, then read back
    dir_rows.push_back(dir_row_t'{CMD_UPDATE, mk(16'h0000, 8'h80, 8'h00, 1'b0, 1'b0), 1'b1,
                                  res_of(16'h0, 0, 8'h00, 8'h00, 32'd0, 0, 0, 0, 5'd1)});
    dir_rows.push_back(dir_row_t'{CMD_UPDATE, mk(16'hFFFF, 8'h7F, 8'hFF, 1'b1, 1'b1), 1'b1,
                                  res_of(16'h0, 0, 8'h00, 8'h00, 32'd0, 0, 0, 0, 5'd2)});
    dir_rows.push_back(dir_row_t'{CMD_TICK, mk(16'h0000, 8'h00, 8'h00, 1'b0, 1'b0), 1'b1,
                                  res_of(16'h0, 0, 8'h00, 8'h00, 32'd0, 0, 0, 0, 5'd2)});
    dir_rows.push_back(dir_row_t'{CMD_FIND, mk(16'hFFFF, 8'h00, 8'h00, 1'b0, 1'b0), 1'b1,
                                  res_of(16'h0, 1, 8'h7F, 8'hFF, 32'd0, 1, 1, 0, 5'd2)});
    // overwrite picks up the new timestamp
    dir_rows.push_back(dir_row_t'{CMD_UPDATE, mk(16'h0000, 8'h05, 8'h03, 1'b1, 1'b0), 1'b1,
                                  res_of(16'h0, 0, 8'h00, 8'h00, 32'd0, 0, 0, 0, 5'd2)});
    dir_rows.push_back(dir_row_t'{CMD_FIND, mk(16'h0000, 8'h00, 8'h00, 1'b0, 1'b0), 1'b1,
                                  res_of(16'h0, 1, 8'h05, 8'h03, 32'd1, 1, 0, 0, 5'd2)});
    dir_rows.push_back(dir_row_t'{CMD_NEXT_HOP, mk(16'hFFFF, 8'h00, 8'h00, 1'b0, 1'b0), 1'b1,
                                  res_of(16'hFFFF, 0, 8'h00, 8'h00, 32'd0, 0, 0, 0, 5'd2)});
    dir_rows.push_back(dir_row_t'{CMD_NEXT_HOP, mk(16'hABCD, 8'h00, 8'h00, 1'b0, 1'b0), 1'b0,
                                  NoRes});
    dir_rows.push_back(dir_row_t'{CMD_UPDATE, mk(16'h8001, 8'h7F, 8'h80, 1'b0, 1'b1), 1'b1,
                                  res_of(16'h0, 0, 8'h00, 8'h00, 32'd0, 0, 0, 0, 5'd3)});
    // tie on the strongest signal
    dir_rows.push_back(dir_row_t'{CMD_NEXT_HOP, mk(16'h1111, 8'h00, 8'h00, 1'b0, 1'b0), 1'b0,
                                  NoRes});
    dir_rows.push_back(dir_row_t'{CmdUnusedLast, mk(16'h5555, 8'h55, 8'hAA, 1'b0, 1'b1), 1'b1,
                                  res_of(16'h0, 0, 8'h00, 8'h00, 32'd0, 0, 0, 0, 5'd3)});
    dir_rows.push_back(dir_row_t'{CMD_UPDATE, mk(16'h5AA5, 8'hFF, 8'h01, 1'b1, 1'b1), 1'b0,
                                  NoRes});
    // zero age limit: older entry removed, last entry moves into its slot
    dir_rows.push_back(dir_row_t'{CMD_PRUNE, mk(16'h0000, 8'h00, 8'h00, 1'b0, 1'b0), 1'b0,
                                  NoRes});
    dir_rows.push_back(dir_row_t'{CMD_FIND, mk(16'hFFFF, 8'h00, 8'h00, 1'b0, 1'b0), 1'b0,
                                  NoRes});
    dir_rows.push_back(dir_row_t'{CMD_FIND, mk(16'h5AA5, 8'h00, 8'h00, 1'b0, 1'b0), 1'b0,
                                  NoRes});
    dir_rows.push_back(dir_row_t'{CMD_NEXT_HOP, mk(16'h4242, 8'h00, 8'h00, 1'b0, 1'b0), 1'b0,
                                  NoRes});
    dir_rows.push_back(dir_row_t'{CMD_TICK, mk(16'h0000, 8'h00, 8'h00, 1'b0, 1'b0), 1'b0,
                                  NoRes});
    dir_rows.push_back(dir_row_t'{CMD_PRUNE, mk(16'h0000, 8'h00, 8'h00, 1'b0, 1'b0), 1'b0,
                                  NoRes});
    dir_rows.push_back(dir_row_t'{CMD_NEXT_HOP, mk(16'h0001, 8'h00, 8'h00, 1'b0, 1'b0), 1'b0,
                                  NoRes});
    dir_rows.push_back(dir_row_t'{CMD_UPDATE, mk(16'h7E57, 8'h81, 8'h7F, 1'b0, 1'b1), 1'b0,
                                  NoRes});

    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].cmd, dir_rows[k].it, dir_rows[k].typed, dir_rows[k].res);
    end
    write_max_age(32'hFFFF_FFFF);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      for (int sp = 0; sp < 4; sp++) begin
        case (sp)
          0: age_val = 32'hFFFF_FFFF;
          1: age_val = 32'd0;
          2: age_val = $urandom_range(12, 1);
          default: age_val = $urandom_range(60, 13);
        endcase
        write_max_age(age_val);
        addr_pool[0] = 16'h0000;
        addr_pool[1] = 16'hFFFF;
        for (int j = 2; j < PoolSize; j++) addr_pool[j] = 16'($urandom);
        // receiver stalls for a long stretch while items keep coming
        if (sp == 0) hold_req = 1'b1;
        for (int n = 0; n < PhaseItems; n++) begin
          pick_random(cmd, it);
          send_item(cmd, it, 1'b0, NoRes);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
